@@ hw/rtl/acdm_pkg.sv @@
// ---------------------------------------------------------------------------
// acdm_pkg : alarm clock display mux, shared types and helpers
// Item and result structs, register indexes, segment fonts and BCD steps.
// ---------------------------------------------------------------------------
`default_nettype none

package acdm_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  // compare width: room for either operand plus one
  localparam int CMP_W = ((COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH) + 1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  localparam cmp_t   CNT_MAX       = cmp_t'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam count_t HOLDOFF_RESET = count_t'(801);

  localparam cfg_word_t HOLDOFF_TICKS_RESET    = cfg_word_t'(800);
  localparam cfg_word_t BEEP_ON_TICKS_RESET    = cfg_word_t'(1000);
  localparam cfg_word_t BEEP_CYCLE_TICKS_RESET = cfg_word_t'(2000);

  typedef enum logic [1:0] {
    REG_HOLDOFF_TICKS    = 2'd0,
    REG_BEEP_ON_TICKS    = 2'd1,
    REG_BEEP_CYCLE_TICKS = 2'd2
  } cfg_reg_e;

  localparam logic FUNC_SECOND  = 1'b0;
  localparam logic FUNC_REFRESH = 1'b1;

  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_MINUTE = 2'd1;
  localparam logic [1:0] BTN_HOUR   = 2'd2;

  typedef logic [3:0] bcd_t;
  typedef bcd_t [0:3] hhmm_t;
  typedef bcd_t [0:5] hhmmss_t;
  typedef logic [6:0] seg_t;

  typedef struct packed {
    logic       func;
    logic [1:0] set_buttons;
    logic       mode_button;
  } item_t;

  typedef struct packed {
    seg_t       segments;
    logic [5:0] digit_select_n;
    logic       beep;
    logic       setting_alarm;
    logic       alarm_ringing;
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
  } result_t;

  typedef struct packed {
    cfg_word_t holdoff_ticks;
    cfg_word_t beep_on_ticks;
    cfg_word_t beep_cycle_ticks;
  } cfg_t;

  localparam seg_t SEG_0 = 7'h3F;
  localparam seg_t SEG_1 = 7'h06;
  localparam seg_t SEG_2 = 7'h5B;
  localparam seg_t SEG_3 = 7'h4F;
  localparam seg_t SEG_4 = 7'h66;
  localparam seg_t SEG_5 = 7'h6D;
  localparam seg_t SEG_6 = 7'h7D;
  localparam seg_t SEG_7 = 7'h07;
  localparam seg_t SEG_8 = 7'h7F;
  localparam seg_t SEG_9 = 7'h6F;
  localparam seg_t SEG_A = 7'h77;
  localparam seg_t SEG_C = 7'h58;
  localparam seg_t SEG_O = 7'h5C;
  localparam seg_t SEG_R = 7'h50;
  localparam seg_t SEG_D = 7'h5E;
  localparam seg_t SEG_BLANK = 7'h00;

  function automatic seg_t font_of(bcd_t v);
    seg_t s;
    unique case (v)
      4'd0:    s = SEG_0;
      4'd1:    s = SEG_1;
      4'd2:    s = SEG_2;
      4'd3:    s = SEG_3;
      4'd4:    s = SEG_4;
      4'd5:    s = SEG_5;
      4'd6:    s = SEG_6;
      4'd7:    s = SEG_7;
      4'd8:    s = SEG_8;
      4'd9:    s = SEG_9;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // letters of ACORDA, leftmost first
  function automatic seg_t word_font(logic [2:0] idx);
    seg_t s;
    unique case (idx)
      3'd0:    s = SEG_A;
      3'd1:    s = SEG_C;
      3'd2:    s = SEG_O;
      3'd3:    s = SEG_R;
      3'd4:    s = SEG_D;
      3'd5:    s = SEG_A;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  function automatic hhmm_t step_hour(hhmm_t d);
    hhmm_t r;
    r = d;
    if (d[1] == 4'd9) begin
      r[1] = 4'd0;
      r[0] = d[0] + 4'd1;
    end else if (d[1] == 4'd3 && d[0] == 4'd2) begin
      r[1] = 4'd0;
      r[0] = 4'd0;
    end else begin
      r[1] = d[1] + 4'd1;
    end
    return r;
  endfunction

  function automatic hhmm_t step_minute(hhmm_t d);
    hhmm_t r;
    r = d;
    if (d[3] == 4'd9) begin
      r[3] = 4'd0;
      if (d[2] == 4'd5) begin
        r[2] = 4'd0;
        r = step_hour(r);
      end else begin
        r[2] = d[2] + 4'd1;
      end
    end else begin
      r[3] = d[3] + 4'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/acdm_core.sv @@
// ---------------------------------------------------------------------------
// acdm_core : clock, alarm and display state
// Holds all item state; computes the next state and result for one item
// and commits it when en is high.
// ---------------------------------------------------------------------------
`default_nettype none

module acdm_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire acdm_pkg::item_t item,
  input  wire acdm_pkg::cfg_t  cfg,
  output acdm_pkg::result_t    res
);

  typedef struct packed {
    logic                  latch;
    acdm_pkg::count_t      hc;
    logic                  step;
  } btn_t;

  acdm_pkg::hhmmss_t clock_digits, clock_digits_next;
  acdm_pkg::hhmm_t   alarm_digits, alarm_digits_next;
  logic              alarm_mode, alarm_mode_next;
  logic              mode_latch;
  logic              minute_latch, minute_latch_next;
  logic              hour_latch, hour_latch_next;
  acdm_pkg::count_t  holdoff_count, holdoff_count_next;
  acdm_pkg::count_t  beep_count, beep_count_next;
  logic              beep_level, beep_level_next;
  logic              blink_phase, blink_phase_next;
  logic [2:0]        digit_index, digit_index_next;
  acdm_pkg::seg_t    segment_reg, segment_reg_next;
  logic [5:0]        select_reg, select_reg_next;

  function automatic acdm_pkg::count_t bump(acdm_pkg::count_t hc,
                                            acdm_pkg::cfg_word_t ticks);
    acdm_pkg::cmp_t lim;
    lim = acdm_pkg::cmp_t'(ticks) + acdm_pkg::cmp_t'(1);
    if (lim > acdm_pkg::CNT_MAX) lim = acdm_pkg::CNT_MAX;
    if (acdm_pkg::cmp_t'(hc) < lim) return hc + acdm_pkg::count_t'(1);
    return hc;
  endfunction

  function automatic btn_t handle(logic [1:0] sb, logic [1:0] want, logic latch,
                                  logic refresh, acdm_pkg::count_t hc,
                                  acdm_pkg::cfg_word_t ticks);
    btn_t b;
    logic ok;
    b.latch = latch;
    b.hc    = hc;
    b.step  = 1'b0;
    ok = !refresh || (acdm_pkg::cmp_t'(hc) > acdm_pkg::cmp_t'(ticks));
    if (sb == want && ok && !latch) begin
      b.latch = 1'b1;
      b.step  = 1'b1;
      if (refresh) b.hc = '0;
    end else if (sb == acdm_pkg::BTN_NONE && ok && latch) begin
      b.latch = 1'b0;
      if (refresh) b.hc = bump(hc, ticks);
    end else if (refresh) begin
      b.hc = bump(hc, ticks);
    end
    return b;
  endfunction

  function automatic logic hhmm_equal(acdm_pkg::hhmmss_t c, acdm_pkg::hhmm_t a);
    return c[0] == a[0] && c[1] == a[1] && c[2] == a[2] && c[3] == a[3];
  endfunction

  always_comb begin
    logic              refresh;
    logic              ring;
    btn_t              bm, bh;
    acdm_pkg::hhmm_t   tgt;
    acdm_pkg::cmp_t    bc_inc;

    refresh         = (item.func == acdm_pkg::FUNC_REFRESH);
    alarm_mode_next = alarm_mode ^ (item.mode_button && !mode_latch);
    ring            = hhmm_equal(clock_digits, alarm_digits);

    clock_digits_next  = clock_digits;
    alarm_digits_next  = alarm_digits;
    blink_phase_next   = blink_phase;
    beep_count_next    = beep_count;
    beep_level_next    = beep_level;
    segment_reg_next   = segment_reg;
    select_reg_next    = select_reg;
    digit_index_next   = digit_index;
    bc_inc             = '0;

    if (refresh) begin
      beep_count_next = beep_count + acdm_pkg::count_t'(1);
      if (ring && acdm_pkg::cmp_t'(beep_count) < acdm_pkg::cmp_t'(cfg.beep_on_ticks)) begin
        beep_level_next = !beep_level;
      end else begin
        bc_inc = acdm_pkg::cmp_t'(beep_count_next);
        if (bc_inc > acdm_pkg::cmp_t'(cfg.beep_cycle_ticks)) beep_count_next = '0;
      end
    end else begin
      blink_phase_next = !blink_phase;
    end

    // set buttons: minute first, hour sees the holdoff count it leaves
    tgt = alarm_mode_next ? alarm_digits : clock_digits[0:3];
    bm  = handle(item.set_buttons, acdm_pkg::BTN_MINUTE, minute_latch, refresh,
                 holdoff_count, cfg.holdoff_ticks);
    if (bm.step) tgt = acdm_pkg::step_minute(tgt);
    bh  = handle(item.set_buttons, acdm_pkg::BTN_HOUR, hour_latch, refresh,
                 bm.hc, cfg.holdoff_ticks);
    if (bh.step) tgt = acdm_pkg::step_hour(tgt);
    minute_latch_next  = bm.latch;
    hour_latch_next    = bh.latch;
    holdoff_count_next = bh.hc;
    if (alarm_mode_next) alarm_digits_next = tgt;
    else clock_digits_next[0:3] = tgt;

    if (!refresh) begin
      if (clock_digits_next[5] == 4'd9) begin
        clock_digits_next[5] = 4'd0;
        if (clock_digits_next[4] == 4'd5) begin
          clock_digits_next[4] = 4'd0;
          clock_digits_next[0:3] = acdm_pkg::step_minute(clock_digits_next[0:3]);
        end else begin
          clock_digits_next[4] = clock_digits_next[4] + 4'd1;
        end
      end else begin
        clock_digits_next[5] = clock_digits_next[5] + 4'd1;
      end
    end

    // display shows the digits as left by this item's button steps
    if (refresh) begin
      if (digit_index < 3'd6) begin
        if (alarm_mode_next) begin
          segment_reg_next = (digit_index < 3'd4)
                           ? acdm_pkg::font_of(alarm_digits_next[digit_index[1:0]])
                           : acdm_pkg::SEG_0;
        end else if (ring) begin
          segment_reg_next = blink_phase ? acdm_pkg::SEG_BLANK
                                         : acdm_pkg::word_font(digit_index);
        end else begin
          segment_reg_next = acdm_pkg::font_of(clock_digits_next[digit_index]);
        end
        select_reg_next = ~(6'd1 << digit_index);
      end else begin
        segment_reg_next = acdm_pkg::SEG_BLANK;
        select_reg_next  = '1;
      end
      digit_index_next = (digit_index == 3'd5) ? 3'd0 : digit_index + 3'd1;
    end

    res.segments       = segment_reg_next;
    res.digit_select_n = select_reg_next;
    res.beep           = beep_level_next;
    res.setting_alarm  = alarm_mode_next;
    res.alarm_ringing  = hhmm_equal(clock_digits_next, alarm_digits_next);
    res.hour_tens      = clock_digits_next[0][1:0];
    res.hour_units     = clock_digits_next[1];
    res.minute_tens    = clock_digits_next[2][2:0];
    res.minute_units   = clock_digits_next[3];
    res.second_tens    = clock_digits_next[4][2:0];
    res.second_units   = clock_digits_next[5];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_digits  <= '0;
      alarm_digits  <= {4'd0, 4'd1, 4'd0, 4'd0};
      alarm_mode    <= 1'b0;
      mode_latch    <= 1'b0;
      minute_latch  <= 1'b0;
      hour_latch    <= 1'b0;
      holdoff_count <= acdm_pkg::HOLDOFF_RESET;
      beep_count    <= '0;
      beep_level    <= 1'b0;
      blink_phase   <= 1'b0;
      digit_index   <= '0;
      segment_reg   <= acdm_pkg::SEG_BLANK;
      select_reg    <= '1;
    end else if (en) begin
      clock_digits  <= clock_digits_next;
      alarm_digits  <= alarm_digits_next;
      alarm_mode    <= alarm_mode_next;
      mode_latch    <= item.mode_button;
      minute_latch  <= minute_latch_next;
      hour_latch    <= hour_latch_next;
      holdoff_count <= holdoff_count_next;
      beep_count    <= beep_count_next;
      beep_level    <= beep_level_next;
      blink_phase   <= blink_phase_next;
      digit_index   <= digit_index_next;
      segment_reg   <= segment_reg_next;
      select_reg    <= select_reg_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/alarm_clock_display_mux_top.sv @@
// ---------------------------------------------------------------------------
// alarm_clock_display_mux_top : BCD alarm clock with 7-segment multiplexing
// Input register, state core and result register.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one item per tick event (one-second tick or display refresh
//           tick) with the set and mode button levels.
//   out_* : one result per item: lit digit pattern and enable, buzzer,
//           mode and ringing flags, and the hour, minute and second digits.
//   cfg_* : register writes (holdoff, beep on, beep cycle), always ready;
//           write only while no item is in flight.
// Path: an accepted item enters the input register, then the core processes
//   it and its result is registered in the result register, which raises
//   out_valid.
// Throughput: one item per cycle while the output is not stalled; the core
//   computes each next state combinationally between the input and result registers.
// Reset: clock 00:00:00, alarm 01:00, setting the clock, all digits off,
//   registers at 800 / 1000 / 2000; both stages empty.
// Stall: a held result keeps its register; the input register still takes
//   one item, then in_stall rises until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module alarm_clock_display_mux_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire acdm_pkg::item_t   in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output acdm_pkg::result_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire acdm_pkg::cfg_word_t cfg_data
);

  logic              in_full;
  acdm_pkg::item_t   in_q;
  acdm_pkg::result_t res;
  acdm_pkg::cfg_t    cfg;
  logic              adv;
  logic              en;

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = in_full && !adv;
  assign en        = in_full && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_q <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.holdoff_ticks    <= acdm_pkg::HOLDOFF_TICKS_RESET;
      cfg.beep_on_ticks    <= acdm_pkg::BEEP_ON_TICKS_RESET;
      cfg.beep_cycle_ticks <= acdm_pkg::BEEP_CYCLE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        acdm_pkg::REG_HOLDOFF_TICKS:    cfg.holdoff_ticks    <= cfg_data;
        acdm_pkg::REG_BEEP_ON_TICKS:    cfg.beep_on_ticks    <= cfg_data;
        acdm_pkg::REG_BEEP_CYCLE_TICKS: cfg.beep_cycle_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  acdm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .item (in_q),
    .cfg  (cfg),
    .res  (res)
  );

endmodule

`default_nettype wire

@@ tb/alarm_clock_display_mux_top_tb.sv @@
// ---------------------------------------------------------------------------
// alarm_clock_display_mux_top_tb : self-checking bench for the alarm clock mux
// Drives tick items with random gaps and output stalls, keeps its own model
// of the clock, alarm, holdoff, beep gate and digit scan, and compares every
// result field by field. Runs a directed opening, then mixed random sequences
// under low, high, small and reset-value register settings.
// ---------------------------------------------------------------------------
`default_nettype none

module alarm_clock_display_mux_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] BTN_BOTH = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  acdm_pkg::item_t     in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  acdm_pkg::result_t   out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = acdm_pkg::REG_HOLDOFF_TICKS;
  acdm_pkg::cfg_word_t cfg_data = '0;

  alarm_clock_display_mux_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  acdm_pkg::result_t expected_frames[$];
  int          errors = 0;
  int          items_sent = 0;
  bit          idle_on = 1'b1;
  int unsigned cycle_count = 0;

  // model state
  acdm_pkg::hhmm_t     tod_hm, alarm_hm;
  acdm_pkg::bcd_t      sec_t, sec_u;
  logic                alarm_mode, mode_latch, min_latch, hr_latch;
  logic                beep_lvl, blink;
  acdm_pkg::count_t    hold_cnt, beep_cnt;
  acdm_pkg::cfg_word_t hold_ticks, beep_on, beep_cycle;
  logic [2:0]          scan_idx;
  acdm_pkg::seg_t      seg_q;
  logic [5:0]          sel_q;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_frames.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 100)
      $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) flag_mismatch(name, got, want);
  endtask

  always @(posedge clk) begin : check_results
    acdm_pkg::result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        flag_mismatch("result with nothing pending", int'(out_data), 0);
      end else begin
        exp_r = expected_frames.pop_front();
        check_field("segments", int'(out_data.segments), int'(exp_r.segments));
        check_field("digit_select_n", int'(out_data.digit_select_n),
                    int'(exp_r.digit_select_n));
        check_field("beep", int'(out_data.beep), int'(exp_r.beep));
        check_field("setting_alarm", int'(out_data.setting_alarm),
                    int'(exp_r.setting_alarm));
        check_field("alarm_ringing", int'(out_data.alarm_ringing),
                    int'(exp_r.alarm_ringing));
        check_field("hour_tens", int'(out_data.hour_tens), int'(exp_r.hour_tens));
        check_field("hour_units", int'(out_data.hour_units), int'(exp_r.hour_units));
        check_field("minute_tens", int'(out_data.minute_tens), int'(exp_r.minute_tens));
        check_field("minute_units", int'(out_data.minute_units),
                    int'(exp_r.minute_units));
        check_field("second_tens", int'(out_data.second_tens), int'(exp_r.second_tens));
        check_field("second_units", int'(out_data.second_units),
                    int'(exp_r.second_units));
      end
    end
  end

  // receiver holds off for a random number of cycles after each item taken while idle_on is set
  initial begin : result_backpressure
    int hold;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        hold = idle_on ? $urandom_range(0, 12) : 0;
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- model
  function automatic acdm_pkg::hhmm_t hour_up(acdm_pkg::hhmm_t d);
    acdm_pkg::hhmm_t r;
    r = d;
    if (d[1] == 4'd9) begin
      r[1] = 4'd0;
      r[0] = d[0] + 4'd1;
    end else if (d[1] == 4'd3 && d[0] == 4'd2) begin
      r[0] = 4'd0;
      r[1] = 4'd0;
    end else begin
      r[1] = d[1] + 4'd1;
    end
    return r;
  endfunction

  function automatic acdm_pkg::hhmm_t minute_up(acdm_pkg::hhmm_t d);
    acdm_pkg::hhmm_t r;
    r = d;
    if (d[3] != 4'd9) begin
      r[3] = d[3] + 4'd1;
    end else begin
      r[3] = 4'd0;
      if (d[2] == 4'd5) begin
        r[2] = 4'd0;
        r = hour_up(r);
      end else begin
        r[2] = d[2] + 4'd1;
      end
    end
    return r;
  endfunction

  function automatic acdm_pkg::seg_t digit_glyph(acdm_pkg::bcd_t v);
    case (v)
      4'd0: return acdm_pkg::SEG_0;
      4'd1: return acdm_pkg::SEG_1;
      4'd2: return acdm_pkg::SEG_2;
      4'd3: return acdm_pkg::SEG_3;
      4'd4: return acdm_pkg::SEG_4;
      4'd5: return acdm_pkg::SEG_5;
      4'd6: return acdm_pkg::SEG_6;
      4'd7: return acdm_pkg::SEG_7;
      4'd8: return acdm_pkg::SEG_8;
      4'd9: return acdm_pkg::SEG_9;
      default: return acdm_pkg::SEG_BLANK;
    endcase
  endfunction

  function automatic acdm_pkg::seg_t letter_glyph(logic [2:0] idx);
    case (idx)
      3'd0: return acdm_pkg::SEG_A;
      3'd1: return acdm_pkg::SEG_C;
      3'd2: return acdm_pkg::SEG_O;
      3'd3: return acdm_pkg::SEG_R;
      3'd4: return acdm_pkg::SEG_D;
      3'd5: return acdm_pkg::SEG_A;
      default: return acdm_pkg::SEG_BLANK;
    endcase
  endfunction

  function automatic void holdoff_bump();
    logic [16:0] lim;
    lim = {1'b0, hold_ticks} + 17'd1;
    if (lim > 17'h0FFFF) lim = 17'h0FFFF;
    if ({1'b0, hold_cnt} < lim) hold_cnt = hold_cnt + 1'b1;
  endfunction

  function automatic void press_step(logic [1:0] sb, logic [1:0] want, bit refresh);
    bit              ok;
    logic            latched;
    acdm_pkg::hhmm_t tgt;
    ok = !refresh || (hold_cnt > hold_ticks);
    latched = (want == acdm_pkg::BTN_MINUTE) ? min_latch : hr_latch;
    tgt = alarm_mode ? alarm_hm : tod_hm;
    if (sb == want && ok && !latched) begin
      latched = 1'b1;
      if (refresh) hold_cnt = '0;
      tgt = (want == acdm_pkg::BTN_MINUTE) ? minute_up(tgt) : hour_up(tgt);
    end else if (sb == acdm_pkg::BTN_NONE && ok && latched) begin
      latched = 1'b0;
      if (refresh) holdoff_bump();
    end else if (refresh) begin
      holdoff_bump();
    end
    if (want == acdm_pkg::BTN_MINUTE) min_latch = latched;
    else hr_latch = latched;
    if (alarm_mode) alarm_hm = tgt;
    else tod_hm = tgt;
  endfunction

  function automatic acdm_pkg::result_t tick_clock(acdm_pkg::item_t it);
    acdm_pkg::result_t r;
    logic              ring;
    logic [2:0]        idx;
    acdm_pkg::bcd_t    shown;
    if (it.mode_button && !mode_latch) alarm_mode = !alarm_mode;
    mode_latch = it.mode_button;
    // beep gate and display go on the match before this item's updates
    ring = (tod_hm == alarm_hm);
    if (it.func == acdm_pkg::FUNC_SECOND) begin
      blink = !blink;
      press_step(it.set_buttons, acdm_pkg::BTN_MINUTE, 1'b0);
      press_step(it.set_buttons, acdm_pkg::BTN_HOUR, 1'b0);
      if (sec_u == 4'd9) begin
        sec_u = 4'd0;
        if (sec_t == 4'd5) begin
          sec_t = 4'd0;
          tod_hm = minute_up(tod_hm);
        end else begin
          sec_t = sec_t + 4'd1;
        end
      end else begin
        sec_u = sec_u + 4'd1;
      end
    end else begin
      idx = scan_idx;
      if (ring && beep_cnt < beep_on) begin
        beep_cnt = beep_cnt + 1'b1;
        beep_lvl = !beep_lvl;
      end else begin
        beep_cnt = beep_cnt + 1'b1;
        if (beep_cnt > beep_cycle) beep_cnt = '0;
      end
      press_step(it.set_buttons, acdm_pkg::BTN_MINUTE, 1'b1);
      press_step(it.set_buttons, acdm_pkg::BTN_HOUR, 1'b1);
      if (idx < 3'd6) begin
        case (idx)
          3'd4: shown = sec_t;
          3'd5: shown = sec_u;
          default: shown = tod_hm[idx[1:0]];
        endcase
        if (alarm_mode) begin
          seg_q = (idx < 3'd4) ? digit_glyph(alarm_hm[idx[1:0]]) : acdm_pkg::SEG_0;
        end else if (ring) begin
          seg_q = blink ? acdm_pkg::SEG_BLANK : letter_glyph(idx);
        end else begin
          seg_q = digit_glyph(shown);
        end
        sel_q = ~(6'd1 << idx);
      end else begin
        seg_q = acdm_pkg::SEG_BLANK;
        sel_q = '1;
      end
      scan_idx = (idx == 3'd5) ? 3'd0 : idx + 3'd1;
    end
    r.segments       = seg_q;
    r.digit_select_n = sel_q;
    r.beep           = beep_lvl;
    r.setting_alarm  = alarm_mode;
    r.alarm_ringing  = (tod_hm == alarm_hm);
    r.hour_tens      = tod_hm[0][1:0];
    r.hour_units     = tod_hm[1];
    r.minute_tens    = tod_hm[2][2:0];
    r.minute_units   = tod_hm[3];
    r.second_tens    = sec_t[2:0];
    r.second_units   = sec_u;
    return r;
  endfunction

  function automatic void reset_model();
    tod_hm     = '0;
    alarm_hm   = {4'd0, 4'd1, 4'd0, 4'd0};
    sec_t      = 4'd0;
    sec_u      = 4'd0;
    alarm_mode = 1'b0;
    mode_latch = 1'b0;
    min_latch  = 1'b0;
    hr_latch   = 1'b0;
    hold_cnt   = acdm_pkg::HOLDOFF_RESET;
    beep_cnt   = '0;
    beep_lvl   = 1'b0;
    blink      = 1'b0;
    scan_idx   = 3'd0;
    seg_q      = acdm_pkg::SEG_BLANK;
    sel_q      = '1;
    hold_ticks = acdm_pkg::HOLDOFF_TICKS_RESET;
    beep_on    = acdm_pkg::BEEP_ON_TICKS_RESET;
    beep_cycle = acdm_pkg::BEEP_CYCLE_TICKS_RESET;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_item(logic func, logic [1:0] sb, logic mb);
    acdm_pkg::item_t it;
    int              gap;
    it.func        = func;
    it.set_buttons = sb;
    it.mode_button = mb;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    expected_frames.push_back(tick_clock(it));
    items_sent++;
  endtask

  // sender goes quiet until every pending result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(acdm_pkg::cfg_reg_e idx, acdm_pkg::cfg_word_t val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      acdm_pkg::REG_HOLDOFF_TICKS:    hold_ticks = val;
      acdm_pkg::REG_BEEP_ON_TICKS:    beep_on = val;
      acdm_pkg::REG_BEEP_CYCLE_TICKS: beep_cycle = val;
      default: ;
    endcase
  endtask

  task automatic write_all(acdm_pkg::cfg_word_t hold, acdm_pkg::cfg_word_t on,
                           acdm_pkg::cfg_word_t cyc);
    write_reg(acdm_pkg::REG_HOLDOFF_TICKS, hold);
    write_reg(acdm_pkg::REG_BEEP_ON_TICKS, on);
    write_reg(acdm_pkg::REG_BEEP_CYCLE_TICKS, cyc);
  endtask

  task automatic toggle_mode();
    if (mode_latch) send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_NONE, 1'b0);
    send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_NONE, 1'b1);
    send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_NONE, 1'b0);
  endtask

  // one step of a set button on a second tick, releasing a held latch first
  task automatic step_on_second(logic [1:0] btn);
    if ((btn == acdm_pkg::BTN_MINUTE) ? min_latch : hr_latch)
      send_item(acdm_pkg::FUNC_SECOND, acdm_pkg::BTN_NONE, mode_latch);
    send_item(acdm_pkg::FUNC_SECOND, btn, mode_latch);
  endtask

  // bring the alarm onto the clock time, then watch it ring in clock mode
  task automatic chase_alarm();
    int guard;
    guard = 0;
    if (!alarm_mode) toggle_mode();
    while (tod_hm != alarm_hm && guard < 110) begin
      step_on_second((tod_hm[2:3] != alarm_hm[2:3]) ? acdm_pkg::BTN_MINUTE
                                                    : acdm_pkg::BTN_HOUR);
      guard++;
    end
    toggle_mode();
    repeat (24)
      send_item(($urandom_range(0, 3) == 0) ? acdm_pkg::FUNC_SECOND : acdm_pkg::FUNC_REFRESH,
                acdm_pkg::BTN_NONE, 1'b0);
  endtask

  task automatic run_mixed(int count);
    int         start;
    int         n;
    logic [1:0] btn;
    start = items_sent;
    while (items_sent - start < count) begin
      idle_on = ($urandom_range(0, 3) != 0);
      btn = $urandom_range(0, 1) ? acdm_pkg::BTN_MINUTE : acdm_pkg::BTN_HOUR;
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 4);
          repeat (n)
            send_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)));
        end
        2, 3: step_on_second(btn);
        4, 5: begin
          n = $urandom_range(3, 14);
          repeat (n) begin
            case ($urandom_range(0, 7))
              5: btn = acdm_pkg::BTN_MINUTE;
              6: btn = acdm_pkg::BTN_HOUR;
              7: btn = BTN_BOTH;
              default: btn = acdm_pkg::BTN_NONE;
            endcase
            send_item(acdm_pkg::FUNC_REFRESH, btn, mode_latch);
          end
        end
        6: toggle_mode();
        7: begin
          n = $urandom_range(1, 10);
          repeat (n) send_item(acdm_pkg::FUNC_SECOND, acdm_pkg::BTN_NONE, mode_latch);
        end
        8: begin
          // press and release under the refresh holdoff
          n = $urandom_range(1, 6);
          repeat (n) send_item(acdm_pkg::FUNC_REFRESH, btn, mode_latch);
          repeat (n) send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_NONE, mode_latch);
        end
        default: begin
          n = $urandom_range(1, 3);
          repeat (n)
            send_item(acdm_pkg::FUNC_SECOND, 2'($urandom_range(0, 3)), mode_latch);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    idle_on = 1'b1;
    // full scan of 00:00:00
    repeat (6) send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_NONE, 1'b0);
    send_item(acdm_pkg::FUNC_SECOND, acdm_pkg::BTN_HOUR, 1'b0);    // 01:00 matches the alarm
    send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_NONE, 1'b0);   // blink phase blanks the word
    send_item(acdm_pkg::FUNC_SECOND, acdm_pkg::BTN_NONE, 1'b0);
    send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_NONE, 1'b0);
    send_item(acdm_pkg::FUNC_REFRESH, BTN_BOTH, 1'b0);
    send_item(acdm_pkg::FUNC_SECOND, BTN_BOTH, 1'b0);
    send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_NONE, 1'b1);   // into alarm setting
    send_item(acdm_pkg::FUNC_SECOND, acdm_pkg::BTN_MINUTE, 1'b1);  // level held, no toggle
    send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_NONE, 1'b0);
    send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_MINUTE, 1'b0);
    send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_NONE, 1'b0);   // held off
    send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_MINUTE, 1'b0);
    send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_NONE, 1'b1);   // back to the clock
    send_item(acdm_pkg::FUNC_SECOND, acdm_pkg::BTN_NONE, 1'b0);
    send_item(acdm_pkg::FUNC_REFRESH, acdm_pkg::BTN_HOUR, 1'b0);
  endtask

  task automatic test_floor_settings();
    write_all(16'd0, 16'd0, 16'd1);
    run_mixed(35);
    settle();
    run_mixed(35);
  endtask

  task automatic test_ceiling_settings();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
    chase_alarm();
    run_mixed(60);
  endtask

  task automatic test_short_beep_cycle();
    acdm_pkg::cfg_word_t on;
    on = acdm_pkg::cfg_word_t'($urandom_range(1, 6));
    write_all(acdm_pkg::cfg_word_t'($urandom_range(1, 4)), on,
              acdm_pkg::cfg_word_t'($urandom_range(32'(on), 12)));
    chase_alarm();
    run_mixed(30);
    settle();
    run_mixed(30);
  endtask

  task automatic test_reset_values();
    write_all(acdm_pkg::HOLDOFF_TICKS_RESET, acdm_pkg::BEEP_ON_TICKS_RESET,
              acdm_pkg::BEEP_CYCLE_TICKS_RESET);
    run_mixed(70);
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    for (int w = 0; w < 2000 && expected_frames.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_frames.size() != 0)
      flag_mismatch("results missing at end", expected_frames.size(), 0);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_floor_settings();
    test_ceiling_settings();
    test_short_beep_cycle();
    test_reset_values();
    finish_run();
  end

endmodule

`default_nettype wire
